@@ rtl/plc_pkg.sv @@
// Shared constants and types for the per-line pattern counter.
`default_nettype none
package plc_pkg;

    // Fixed field widths
    localparam int CH_WIDTH    = 8;
    localparam int LINE_WIDTH  = 16;
    localparam int OCC_WIDTH   = 16;
    localparam int LEN_WIDTH   = 4;
    localparam int PAT_WIDTH   = 64;
    localparam int CFG_WIDTH   = 64;
    localparam int PAT_BYTES   = 8;

    // Parameter defaults
    localparam int PATTERN_MAX_DEFAULT = 8;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Text constants
    localparam logic [CH_WIDTH-1:0]   NEWLINE    = 8'd10;
    localparam logic [LINE_WIDTH-1:0] FIRST_LINE = 16'd2;
    localparam logic [LINE_WIDTH-1:0] LINE_LAST  = 16'hFFFF;
    localparam logic [OCC_WIDTH-1:0]  OCC_LAST   = 16'hFFFF;

    // Register indexes
    localparam logic CFG_PATTERN_BYTES  = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    // One history cell's contents
    typedef struct packed {
        logic [CH_WIDTH-1:0] data;
        logic                valid;
    } t_cell_out;

    // One result beat
    typedef struct packed {
        logic [LINE_WIDTH-1:0] line_number;
        logic [OCC_WIDTH-1:0]  occurrences;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/plc_cell.sv @@
// One history cell: holds a past byte of the line and compares it to its pattern byte.
`default_nettype none
module plc_cell
    import plc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire logic                i_clear,
    input  wire t_cell_out           i_prev,
    input  wire logic [CH_WIDTH-1:0] i_pat_byte,
    input  wire logic                i_active,
    output t_cell_out                o_state,
    output logic                     o_ok
);

    logic [CH_WIDTH-1:0] r_data;
    logic                r_valid;

    // valid bit clears on newline, data needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev.data;
        end
    end

    assign o_state.data  = r_data;
    assign o_state.valid = r_valid;

    // an unused cell never blocks a match
    assign o_ok = !i_active || (r_valid && (r_data == i_pat_byte));

endmodule
`default_nettype wire

@@ rtl/plc_track.sv @@
// Match blocking, per-line count and line number tracking.
`default_nettype none
module plc_track
    import plc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_beat,
    input  wire logic                 i_newline,
    input  wire logic                 i_match,
    input  wire logic [LEN_WIDTH-1:0] i_len,
    output logic                      o_push,
    output t_result                   o_result
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [2:0]             r_blocked;
    logic [LINE_WIDTH-1:0]  r_line;
    logic [31:0]            w_count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_blocked <= '0;
            r_line    <= FIRST_LINE;
        end else if (i_beat && i_newline) begin
            r_count   <= '0;
            r_blocked <= '0;
            if (r_line != LINE_LAST) begin
                r_line <= r_line + 1'b1;
            end
        end else if (i_beat) begin
            // bytes inside a counted match cannot end another one
            if (r_blocked != 3'd0) begin
                r_blocked <= r_blocked - 1'b1;
            end else if (i_match) begin
                if (r_count != {COUNT_WIDTH{1'b1}}) begin
                    r_count <= r_count + 1'b1;
                end
                r_blocked <= 3'(i_len - 4'd1);
            end
        end
    end

    // result for the line that ends on this beat
    assign w_count_ext          = 32'(r_count);
    assign o_push               = i_beat && i_newline;
    assign o_result.line_number = r_line;
    assign o_result.occurrences = (w_count_ext > 32'(OCC_LAST)) ? OCC_LAST
                                                                : w_count_ext[OCC_WIDTH-1:0];

endmodule
`default_nettype wire

@@ rtl/plc_outq.sv @@
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module plc_outq
    import plc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_valid,
    output t_result      o_result,
    output logic         o_full
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_take;

    assign w_take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_result;
            end else begin
                n_out_valid = i_push;
                n_out       = i_result;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

endmodule
`default_nettype wire

@@ rtl/per_line_pattern_counter_top.sv @@
// Top level of the per-line pattern counter: config registers, cell chain, tracking, output.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   ch      | in        | i_ch_valid / o_ch_stall  | i_ch
//   result  | out       | o_res_valid / i_res_stall| o_line_number, o_occurrences
//   config  | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_ch_stall is low; the cell compare and the count update
// settle in the same cycle. Each result is held in the output or the skid register.
// Reset empties the history cells and the result buffer and sets the line number to 2.
// Input stalls only while two results wait; the output register and a skid register
// hold them.
`default_nettype none
module per_line_pattern_counter_top
    import plc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_ch_valid,
    output logic                       o_ch_stall,
    input  wire logic [CH_WIDTH-1:0]   i_ch,
    output logic                       o_res_valid,
    input  wire logic                  i_res_stall,
    output logic [LINE_WIDTH-1:0]      o_line_number,
    output logic [OCC_WIDTH-1:0]       o_occurrences,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  i_cfg_data
);

    // longest usable pattern and the history it needs
    localparam int LEN_LIMIT = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int HIST      = (LEN_LIMIT > 1) ? LEN_LIMIT - 1 : 1;

    logic [PAT_WIDTH-1:0] r_pat;
    logic [LEN_WIDTH-1:0] r_len;
    logic [LEN_WIDTH-1:0] w_len;
    logic                 w_beat;
    logic                 w_newline;
    logic                 w_match;
    logic [2:0]           w_last_idx;
    logic [HIST-1:0]      w_ok;
    t_cell_out            w_cell [HIST];
    t_cell_out            w_head;
    t_result              w_push_res;
    t_result              w_out_res;
    logic                 w_push;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= LEN_WIDTH'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pat <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len <= i_cfg_data[LEN_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // clamp the length into the usable range
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_WIDTH'(1);
        end else if (r_len > LEN_WIDTH'(LEN_LIMIT)) begin
            w_len = LEN_WIDTH'(LEN_LIMIT);
        end else begin
            w_len = r_len;
        end
    end

    assign w_beat    = i_ch_valid && !o_ch_stall;
    assign w_newline = (i_ch == NEWLINE);

    // the current byte feeds the head of the chain
    assign w_head.data  = i_ch;
    assign w_head.valid = 1'b1;

    // history chain: cell j holds the byte j+1 places back
    for (genvar j = 0; j < HIST; j++) begin : g_cell
        logic [LEN_WIDTH-1:0] w_pidx;
        logic                 w_active;
        logic [CH_WIDTH-1:0]  w_pat_byte;

        assign w_active   = (w_len >= LEN_WIDTH'(j + 2));
        assign w_pidx     = w_len - LEN_WIDTH'(j + 2);
        assign w_pat_byte = r_pat[{w_pidx[2:0], 3'b000} +: CH_WIDTH];

        plc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_beat && !w_newline),
            .i_clear    (w_beat && w_newline),
            .i_prev     ((j == 0) ? w_head : w_cell[(j == 0) ? 0 : j - 1]),
            .i_pat_byte (w_pat_byte),
            .i_active   (w_active),
            .o_state    (w_cell[j]),
            .o_ok       (w_ok[j])
        );
    end

    // last pattern byte against the incoming byte, rest from the cells
    assign w_last_idx = 3'(w_len - 4'd1);
    assign w_match    = (r_pat[{w_last_idx, 3'b000} +: CH_WIDTH] == i_ch) && (&w_ok);

    plc_track #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .i_newline (w_newline),
        .i_match   (w_match),
        .i_len     (w_len),
        .o_push    (w_push),
        .o_result  (w_push_res)
    );

    plc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_push_res),
        .i_stall  (i_res_stall),
        .o_valid  (o_res_valid),
        .o_result (w_out_res),
        .o_full   (o_ch_stall)
    );

    assign o_line_number = w_out_res.line_number;
    assign o_occurrences = w_out_res.occurrences;

endmodule
`default_nettype wire

@@ rtl/plc_checker.sv @@
// Port-level assertions for the per-line pattern counter and their bind.
`default_nettype none
module plc_checker
    import plc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_ch_valid,
    input wire logic                o_ch_stall,
    input wire logic [CH_WIDTH-1:0] i_ch,
    input wire logic                o_res_valid,
    input wire logic                i_res_stall
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // a newline beat always yields a pending result
    a_newline_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ch_valid && !o_ch_stall && i_ch == NEWLINE) |=> o_res_valid)
        else $error("newline beat gave no result");

    // a plain byte into an empty buffer gives nothing
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_res_valid && !(i_ch_valid && !o_ch_stall && i_ch == NEWLINE)) |=> !o_res_valid)
        else $error("result without newline");

    // input stalls only while a result is waiting
    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ch_stall |-> o_res_valid)
        else $error("input stalled with no result pending");

    // a stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> o_res_valid)
        else $error("stalled result dropped");

endmodule

bind per_line_pattern_counter_top plc_checker u_plc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_ch_valid  (i_ch_valid),
    .o_ch_stall  (o_ch_stall),
    .i_ch        (i_ch),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall)
);
`default_nettype wire
